>>> rtl/button_click_gesture_classifier_assert.svh
// Assertion macros shared by the button click gesture classifier RTL.
// Depends on clk_i and rst_ni being in scope where the macros are used.
`ifndef BUTTON_CLICK_GESTURE_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_GESTURE_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every rising edge of clk_i, switched off while in reset
`define BCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge of clk_i, reset included
`define BCG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define BCG_ASSERT(lbl, prop, msg)
`define BCG_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/bcg_pkg.sv
// Package for the button click gesture classifier: payload and config types,
// event codes, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package bcg_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEBOUNCE     = 2'd0,
    CFG_LONG_PRESS   = 2'd1,
    CFG_DOUBLE_CLICK = 2'd2
  } bcg_cfg_idx_e;

  localparam logic [CfgW-1:0] DebounceRst    = 16'd25;
  localparam logic [CfgW-1:0] LongPressRst   = 16'd700;
  localparam logic [CfgW-1:0] DoubleClickRst = 16'd300;

  // Button A key events
  typedef enum logic [1:0] {
    A_NONE    = 2'd0,
    A_PRESS   = 2'd1,
    A_RELEASE = 2'd2
  } bcg_a_event_e;

  // Button B gesture actions
  typedef enum logic [1:0] {
    B_NONE   = 2'd0,
    B_SINGLE = 2'd1,
    B_DOUBLE = 2'd2,
    B_LONG   = 2'd3
  } bcg_b_action_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             level_a;
    logic             level_b;
    logic             link_up;
  } bcg_in_t;

  typedef struct packed {
    bcg_a_event_e  a_event;
    bcg_b_action_e b_action;
  } bcg_out_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] double_click_ms;
  } bcg_cfg_t;

  // Debounced level of one button for the current sample and the one before
  typedef struct packed {
    logic cur;
    logic prev;
  } bcg_level_t;

endpackage

>>> rtl/button_click_gesture_classifier.sv
// Button click gesture classifier: one result transaction per sample
// transaction, accepted one per cycle while the result register is free or
// being read. A sample is taken into the input register and its result is
// loaded into the result register when that one is free (input register,
// then result register); while out_ready_i is low with a result waiting, the
// sample stays in the input register. Every sample gives exactly one result,
// with zero codes when nothing happened. The debounce and gesture state is
// updated as a sample moves from the input register to the result register.
// Configuration writes are always accepted (cfg_ready_o is tied high);
// reset loads debounce 25 ms, long press 700 ms and double click 300 ms.
// Depends on bcg_pkg, bcg_debounce and bcg_classify.
`timescale 1ns / 1ps
`include "button_click_gesture_classifier_assert.svh"

module button_click_gesture_classifier (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  bcg_pkg::bcg_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output bcg_pkg::bcg_out_t        out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  bcg_pkg::bcg_cfg_idx_e    cfg_index_i,
  input  logic [bcg_pkg::CfgW-1:0] cfg_data_i
);
  import bcg_pkg::*;

  bcg_cfg_t   cfg_q;
  bcg_in_t    in_q;
  logic       in_valid_q;
  bcg_out_t   out_q;
  logic       out_valid_q;
  logic       advance;
  bcg_level_t lvl_a, lvl_b;
  bcg_out_t   result;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DebounceRst;
      cfg_q.long_press_ms   <= LongPressRst;
      cfg_q.double_click_ms <= DoubleClickRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE:     cfg_q.debounce_ms     <= cfg_data_i;
        CFG_LONG_PRESS:   cfg_q.long_press_ms   <= cfg_data_i;
        CFG_DOUBLE_CLICK: cfg_q.double_click_ms <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // Handshake: the sample moves on whenever the result register is free or being read
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Debouncers
  bcg_debounce u_deb_a (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .raw_i         (in_q.level_a),
    .now_i         (in_q.now_ms),
    .debounce_ms_i (cfg_q.debounce_ms),
    .level_o       (lvl_a)
  );

  bcg_debounce u_deb_b (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .raw_i         (in_q.level_b),
    .now_i         (in_q.now_ms),
    .debounce_ms_i (cfg_q.debounce_ms),
    .level_o       (lvl_b)
  );

  // Gesture classification
  bcg_classify u_classify (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .now_i     (in_q.now_ms),
    .link_up_i (in_q.link_up),
    .lvl_a_i   (lvl_a),
    .lvl_b_i   (lvl_b),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BCG_ASSERT(result_from_sample,
    $rose(out_valid_q) |-> $past(in_valid_q),
    "result appeared without a sample in the input register")
  `BCG_ASSERT(stalled_sample_kept,
    in_valid_q && !advance |=> in_valid_q && $stable(in_q),
    "waiting sample lost or changed")
  `BCG_ASSERT_ALWAYS(no_result_in_reset,
    !rst_ni |=> !out_valid_q && !in_valid_q,
    "valid flags set during reset")

endmodule

>>> rtl/bcg_debounce.sv
// Lockout debouncer for one button: holds the debounced level and the time
// of the last accepted change. Depends on bcg_pkg.
`timescale 1ns / 1ps

module bcg_debounce (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      raw_i,
  input  logic [bcg_pkg::TimeW-1:0] now_i,
  input  logic [bcg_pkg::CfgW-1:0]  debounce_ms_i,
  output bcg_pkg::bcg_level_t       level_o
);
  import bcg_pkg::*;

  logic             level_q, level_d;
  logic [TimeW-1:0] when_q, when_d;
  logic [TimeW-1:0] since;
  logic             take;

  // Accept a change only once the lockout time has run out (wrapping time)
  always_comb begin
    since   = now_i - when_q;
    take    = (raw_i != level_q) && (since >= {{(TimeW-CfgW){1'b0}}, debounce_ms_i});
    level_d = take ? raw_i : level_q;
    when_d  = take ? now_i : when_q;
  end

  // The level seen by the previous sample is the stored one
  assign level_o.cur  = level_d;
  assign level_o.prev = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      when_q  <= '0;
    end else if (step_i) begin
      level_q <= level_d;
      when_q  <= when_d;
    end
  end

endmodule

>>> rtl/bcg_classify.sv
// Gesture logic: hold-key press/release for button A and single, double
// and long press classification for button B. Depends on bcg_pkg.
`timescale 1ns / 1ps
`include "button_click_gesture_classifier_assert.svh"

module bcg_classify (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [bcg_pkg::TimeW-1:0] now_i,
  input  logic                      link_up_i,
  input  bcg_pkg::bcg_level_t       lvl_a_i,
  input  bcg_pkg::bcg_level_t       lvl_b_i,
  input  bcg_pkg::bcg_cfg_t         cfg_i,
  output bcg_pkg::bcg_out_t         result_o
);
  import bcg_pkg::*;

  logic             hold_q, hold_d;
  logic             cons_q, cons_d;
  logic             pend_q, pend_d;
  logic [TimeW-1:0] press_q, press_d;
  logic [TimeW-1:0] rel_q, rel_d;

  logic             a_rise, a_fall, a_press, a_release;
  logic             b_rise, b_fall;
  logic [TimeW-1:0] since_rel_old, since_press, since_rel;
  logic [TimeW-1:0] long_ms, dbl_ms;
  logic             dbl, long_hit, single, new_release;
  logic             cons1, cons2, pend1, pend2;
  bcg_b_action_e    b_act;

  assign long_ms = {{(TimeW-CfgW){1'b0}}, cfg_i.long_press_ms};
  assign dbl_ms  = {{(TimeW-CfgW){1'b0}}, cfg_i.double_click_ms};

  // Button A: press only with the link up, release whenever the key is held
  always_comb begin
    a_rise    = lvl_a_i.cur & ~lvl_a_i.prev;
    a_fall    = ~lvl_a_i.cur & lvl_a_i.prev;
    a_press   = a_rise & ~hold_q & link_up_i;
    a_release = a_fall & hold_q;
    hold_d    = a_press | (hold_q & ~a_release);
  end

  // Button B: double click on press, long press while held, single click
  // once the window after a release has closed
  always_comb begin
    b_rise        = lvl_b_i.cur & ~lvl_b_i.prev;
    b_fall        = ~lvl_b_i.cur & lvl_b_i.prev;
    since_rel_old = now_i - rel_q;

    dbl     = b_rise & pend_q & (since_rel_old < dbl_ms);
    press_d = (b_rise & ~dbl) ? now_i : press_q;
    cons1   = b_rise ? dbl : cons_q;
    pend1   = pend_q & ~dbl;

    // a fresh press starts its hold time at zero
    since_press = (b_rise & ~dbl) ? '0 : (now_i - press_q);
    long_hit    = lvl_b_i.cur & ~cons1 & (since_press >= long_ms);
    cons2       = cons1 | long_hit;

    new_release = b_fall & ~cons2;
    pend2       = pend1 | new_release;
    rel_d       = new_release ? now_i : rel_q;
    cons_d      = cons2 & ~b_fall;

    since_rel = new_release ? '0 : since_rel_old;
    single    = pend2 & ~lvl_b_i.cur & (since_rel >= dbl_ms);
    pend_d    = pend2 & ~single;

    b_act = B_NONE;
    priority if (single)   b_act = B_SINGLE;
    else if (long_hit)     b_act = B_LONG;
    else if (dbl)          b_act = B_DOUBLE;
  end

  // Result for this sample; B actions are muted while the link is down
  always_comb begin
    result_o.a_event  = a_press ? A_PRESS : (a_release ? A_RELEASE : A_NONE);
    result_o.b_action = link_up_i ? b_act : B_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 1'b0;
      cons_q  <= 1'b0;
      pend_q  <= 1'b0;
      press_q <= '0;
      rel_q   <= '0;
    end else if (step_i) begin
      hold_q  <= hold_d;
      cons_q  <= cons_d;
      pend_q  <= pend_d;
      press_q <= press_d;
      rel_q   <= rel_d;
    end
  end

  `BCG_ASSERT(a_release_needs_hold,
    step_i && result_o.a_event == A_RELEASE |-> hold_q,
    "A release reported without the key held")
  `BCG_ASSERT(a_press_needs_link,
    step_i && result_o.a_event == A_PRESS |-> link_up_i && !hold_q,
    "A press reported with link down or key already held")
  `BCG_ASSERT(state_holds_when_idle,
    !step_i |=> $stable(hold_q) && $stable(pend_q) && $stable(press_q) && $stable(rel_q),
    "gesture state moved without a sample")

endmodule
